/* design/iblm_pkg.sv */
// Package for the indexed bucket list manager.
// Holds default sizes, operation and error codes. No dependencies.
`timescale 1ns / 1ps
package iblm_pkg;
  localparam int POOL_ENTRIES_DEF = 4096;
  localparam int SECTOR_LISTS_DEF = 1024;
  localparam int STATUS_LISTS_DEF = 1024;

  localparam logic [1:0] FUNC_ALLOC      = 2'd0;
  localparam logic [1:0] FUNC_DELETE     = 2'd1;
  localparam logic [1:0] FUNC_CHG_SECTOR = 2'd2;
  localparam logic [1:0] FUNC_CHG_STATUS = 2'd3;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_EMPTY    = 2'd1;
  localparam logic [1:0] ERR_NOT_USED = 2'd2;
endpackage

/* design/indexed_bucket_list_manager.sv */
// Top level of the indexed bucket list manager.
// Depends on iblm_pkg and iblm_ram.
`timescale 1ns / 1ps
// The block keeps a pool of entries on doubly linked sector and status lists,
// all held in on-chip memories. After reset a clearing pass (six words per
// entry, one word a cycle, heads and counts swept alongside) builds the free
// chain; no transaction is accepted during it. After that each operation is a
// short sequence of single memory accesses on one read port and one write port
// per memory, each read passing through issue, wait and consume steps. An entry
// index beyond the pool is answered from the idle state without a memory access,
// an entry not in use after its status read, an allocate on an empty pool after
// the free head and count reads. One operation is worked at a time; the next
// transaction is taken only in the idle state, and only while the result
// register is empty or is being read in that cycle.
module indexed_bucket_list_manager
  import iblm_pkg::*;
#(
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
  parameter int SECTOR_LISTS = SECTOR_LISTS_DEF,
  parameter int STATUS_LISTS = STATUS_LISTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [11:0] entry,
  input  logic [9:0]  sector,
  input  logic [9:0]  status,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] result_entry,
  output logic [1:0]  error,
  output logic [12:0] status_count
);
  // Widths. Links carry one extra bit for the empty code.
  localparam int EW = $clog2(POOL_ENTRIES);
  localparam int SEW = (SECTOR_LISTS > 1) ? $clog2(SECTOR_LISTS) : 1;
  localparam int STW = $clog2(STATUS_LISTS + 1);
  localparam int CW = $clog2(POOL_ENTRIES + 1);
  localparam int LW = EW + 1;
  localparam int SD = (SECTOR_LISTS > 1) ? SECTOR_LISTS : 2;

  // One shared memory for all per-entry words and one for heads and counts,
  // each addressed by a region tag in the top bits.
  // Entry memory layout: region 0 sprev, 1 snext, 2 tprev, 3 tnext,
  // 4 entry sector (sector plus none bit), 5 entry status.
  localparam int DW0 = (LW > SEW + 1) ? LW : SEW + 1;
  localparam int DW1 = (DW0 > STW) ? DW0 : STW;
  localparam int DW = (DW1 > CW) ? DW1 : CW;
  localparam int EA = EW + 3;
  localparam int HW = (SEW > STW) ? SEW : STW;
  localparam int HA = HW + 2;

  localparam logic [2:0] R_SPREV = 3'd0;
  localparam logic [2:0] R_SNEXT = 3'd1;
  localparam logic [2:0] R_TPREV = 3'd2;
  localparam logic [2:0] R_TNEXT = 3'd3;
  localparam logic [2:0] R_ESEC  = 3'd4;
  localparam logic [2:0] R_ESTA  = 3'd5;
  localparam logic [1:0] H_SHEAD = 2'd0;
  localparam logic [1:0] H_THEAD = 2'd1;
  localparam logic [1:0] H_CNT   = 2'd2;

  localparam logic [LW-1:0] EMPTY = {LW{1'b1}};
  localparam logic [STW-1:0] FREE_B = STW'(STATUS_LISTS);

  // Sequencer codes. Each micro step issues at most one read and at most one write per memory.
  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_RD    = 5'd2;  // issue read, addr in rd_ea or rd_ha
  localparam logic [4:0] S_RW    = 5'd3;  // wait data
  localparam logic [4:0] S_EXEC  = 5'd4;  // consume data, choose next step
  localparam logic [4:0] S_DONE  = 5'd5;

  logic [4:0] state;
  logic [5:0] pc, ret_pc;

  // Entry RAM ports.
  logic          e_we;
  logic [EA-1:0] e_wa, e_ra;
  logic [DW-1:0] e_wd, e_rd;
  // Head RAM ports.
  logic          h_we;
  logic [HA-1:0] h_wa, h_ra;
  logic [DW-1:0] h_wd, h_rd;

  iblm_ram #(.WIDTH(DW), .DEPTH(8 * POOL_ENTRIES)) u_ent (
    .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd)
  );
  iblm_ram #(.WIDTH(DW), .DEPTH(4 << HW)) u_head (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
  );

  // Operation registers.
  logic [1:0]     op;
  logic [11:0]    op_entry;
  logic [EW-1:0]  e;
  logic [SEW-1:0] tsec;
  logic [STW-1:0] tsta, old_sta;
  logic [SEW:0]   old_sec;
  logic [LW-1:0]  hd, nx, pv, tl;
  logic [CW-1:0]  cnt;
  logic [EW:0]    clr;
  logic           rd_ent;
  logic [EA-1:0]  rd_ea;
  logic [HA-1:0]  rd_ha;
  // List selection for the shared unlink/append subroutines.
  logic           lsec;        // 1 sector list, 0 status list
  logic [HW-1:0]  lidx;

  // Output register.
  logic           res_v;
  logic [11:0]    res_e;
  logic [1:0]     res_err;
  logic [12:0]    res_cnt;

  assign in_ready = (state == S_IDLE) && (!res_v || out_ready);
  assign out_valid = res_v;
  assign result_entry = res_e;
  assign error = res_err;
  assign status_count = res_cnt;

  // Saturated targets.
  logic [SEW-1:0] sat_sec;
  logic [STW-1:0] sat_sta;
  always_comb begin
    sat_sec = ({22'd0, sector} >= 32'(SECTOR_LISTS)) ? SEW'(SECTOR_LISTS - 1)
                                                       : SEW'(sector);
    sat_sta = ({22'd0, status} >= 32'(STATUS_LISTS)) ? STW'(STATUS_LISTS - 1)
                                                       : STW'(status);
  end

  function automatic logic [EA-1:0] ea(input logic [2:0] r, input logic [LW-1:0] i);
    ea = {r, i[EW-1:0]};
  endfunction
  function automatic logic [HA-1:0] ha(input logic [1:0] r, input logic [HW-1:0] i);
    ha = {r, i};
  endfunction

  logic [EA-1:0] prevr, nextr;
  logic [HW-1:0] hidx;
  always_comb begin
    prevr = lsec ? {R_SPREV, {EW{1'b0}}} : {R_TPREV, {EW{1'b0}}};
    nextr = lsec ? {R_SNEXT, {EW{1'b0}}} : {R_TNEXT, {EW{1'b0}}};
    hidx = lidx;
  end
  logic [1:0] hreg;
  assign hreg = lsec ? H_SHEAD : H_THEAD;
  logic [DW-1:0] rdat;
  assign rdat = rd_ent ? e_rd : h_rd;

  // Micro program counter values.
  // Top sequence: 1..3 first reads, 30..42 follow-ups. Unlink 10..15, append 20..26, return via ret_pc.
  always_ff @(posedge clk) begin
    e_we <= 1'b0;
    h_we <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      res_v <= 1'b0;
      pc <= '0;
    end else begin
      if (res_v && out_ready) res_v <= 1'b0;
      unique case (state)
        // Sweep entries, heads and counts after reset.
        S_CLEAR: begin
          e_we <= 1'b1;
          h_we <= 1'b1;
          if (pc == 6'd0) begin
            e_wa <= ea(R_SPREV, LW'(clr)); e_wd <= '0;
            h_wa <= ha(H_SHEAD, HW'(clr)); h_wd <= DW'(EMPTY);
          end else if (pc == 6'd1) begin
            e_wa <= ea(R_SNEXT, LW'(clr)); e_wd <= DW'(EMPTY);
            h_wa <= ha(H_THEAD, HW'(clr));
            h_wd <= (clr == (EW + 1)'(STATUS_LISTS)) ? '0 : DW'(EMPTY);
          end else if (pc == 6'd2) begin
            e_wa <= ea(R_TPREV, LW'(clr));
            e_wd <= (clr == '0) ? DW'(POOL_ENTRIES - 1) : DW'(clr - 1'b1);
            h_wa <= ha(H_CNT, HW'(clr));
            h_wd <= (clr == (EW + 1)'(STATUS_LISTS)) ? DW'(POOL_ENTRIES) : '0;
          end else if (pc == 6'd3) begin
            e_wa <= ea(R_TNEXT, LW'(clr));
            e_wd <= (clr == (EW + 1)'(POOL_ENTRIES - 1)) ? DW'(EMPTY) : DW'(clr + 1'b1);
            h_we <= 1'b0;
          end else if (pc == 6'd4) begin
            e_wa <= ea(R_ESEC, LW'(clr)); e_wd <= DW'({1'b1, {SEW{1'b0}}});
            h_we <= 1'b0;
          end else begin
            e_wa <= ea(R_ESTA, LW'(clr)); e_wd <= DW'(FREE_B);
            h_we <= 1'b0;
          end
          // Heads sweep only while the index is in their range.
          if (32'(clr) >= 32'(1 << HW)) h_we <= 1'b0;
          if (pc == 6'd5) begin
            pc <= '0;
            if (clr == (EW + 1)'(POOL_ENTRIES - 1) &&
                32'(POOL_ENTRIES) >= 32'(SD) && 32'(POOL_ENTRIES) > 32'(STATUS_LISTS)) begin
              state <= S_IDLE;
            end else if (clr >= (EW + 1)'(POOL_ENTRIES - 1) &&
                         32'(clr) >= 32'(SD - 1) && 32'(clr) >= 32'(STATUS_LISTS)) begin
              state <= S_IDLE;
            end
            clr <= clr + 1'b1;
          end else begin
            pc <= pc + 1'b1;
          end
          if (32'(clr) >= 32'(POOL_ENTRIES)) e_we <= 1'b0;
        end
        // Take a transaction and start its micro program, or answer an entry beyond the pool directly.
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op <= func;
            op_entry <= entry;
            e <= EW'(entry);
            tsec <= sat_sec;
            tsta <= sat_sta;
            if (func == FUNC_ALLOC) begin
              rd_ent <= 1'b0; rd_ha <= ha(H_THEAD, HW'(FREE_B)); pc <= 6'd1;
              state <= S_RD;
            end else if ({20'd0, entry} >= 32'(POOL_ENTRIES)) begin
              res_v <= 1'b1; res_e <= entry; res_err <= ERR_NOT_USED; res_cnt <= '0;
            end else begin
              rd_ent <= 1'b1; rd_ea <= ea(R_ESTA, LW'(entry)); pc <= 6'd2;
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_RW;
        end
        S_RW: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_RD;
          unique case (pc)
            // Allocate: free head read.
            6'd1: begin
              if (rdat[LW-1:0] == EMPTY || 32'(rdat[LW-1:0]) >= 32'(POOL_ENTRIES)) begin
                res_e <= '0; res_err <= ERR_EMPTY;
                rd_ent <= 1'b0; rd_ha <= ha(H_CNT, HW'(tsta)); pc <= 6'd40;
              end else begin
                e <= rdat[EW-1:0]; res_e <= 12'(rdat[EW-1:0]); res_err <= ERR_OK;
                old_sta <= FREE_B;
                lsec <= 1'b0; lidx <= HW'(FREE_B); ret_pc <= 6'd30;
                rd_ent <= 1'b0; rd_ha <= ha(H_THEAD, HW'(FREE_B)); pc <= 6'd10;
              end
            end
            // Status of the given entry.
            6'd2: begin
              old_sta <= rdat[STW-1:0];
              res_e <= op_entry;
              if (rdat[STW-1:0] >= FREE_B) begin
                res_v <= 1'b1; res_err <= ERR_NOT_USED; res_cnt <= '0; state <= S_DONE;
              end else begin
                res_err <= ERR_OK;
                rd_ent <= 1'b1; rd_ea <= ea(R_ESEC, LW'(e)); pc <= 6'd3;
              end
            end
            6'd3: begin
              old_sec <= rdat[SEW:0];
              if (op == FUNC_CHG_SECTOR) begin
                lsec <= 1'b1; lidx <= HW'(rdat[SEW-1:0]); ret_pc <= 6'd33;
                rd_ent <= 1'b0; rd_ha <= ha(H_SHEAD, HW'(rdat[SEW-1:0]));
                pc <= rdat[SEW] ? 6'd33 : 6'd10;
                if (rdat[SEW]) state <= S_EXEC;
              end else begin
                lsec <= 1'b0; lidx <= HW'(old_sta);
                ret_pc <= (op == FUNC_DELETE) ? 6'd31 : 6'd30;
                rd_ent <= 1'b0; rd_ha <= ha(H_THEAD, HW'(old_sta)); pc <= 6'd10;
              end
            end
            // Unlink: head read.
            6'd10: begin
              hd <= rdat[LW-1:0];
              rd_ent <= 1'b1; rd_ea <= nextr | ea(3'd0, LW'(e)); pc <= 6'd11;
            end
            6'd11: begin
              nx <= rdat[LW-1:0];
              rd_ent <= 1'b1; rd_ea <= prevr | ea(3'd0, LW'(e)); pc <= 6'd12;
            end
            6'd12: begin
              pv <= rdat[LW-1:0];
              e_we <= 1'b1;
              e_wa <= prevr | ea(3'd0, (nx == EMPTY) ? hd : nx);
              e_wd <= DW'(rdat[EW-1:0]);
              if (hd != LW'(e)) begin
                pc <= 6'd13;
              end else begin
                h_we <= 1'b1; h_wa <= ha(hreg, hidx); h_wd <= DW'(nx);
                pc <= 6'd14;
              end
              state <= S_EXEC;
            end
            6'd13: begin
              e_we <= 1'b1; e_wa <= nextr | ea(3'd0, pv); e_wd <= DW'(nx);
              pc <= 6'd14; state <= S_EXEC;
            end
            6'd14: begin
              if (lsec) begin
                pc <= ret_pc; state <= S_EXEC;
              end else begin
                rd_ent <= 1'b0; rd_ha <= ha(H_CNT, hidx); pc <= 6'd15;
              end
            end
            6'd15: begin
              h_we <= 1'b1; h_wa <= ha(H_CNT, hidx); h_wd <= DW'(rdat[CW-1:0] - 1'b1);
              cnt <= rdat[CW-1:0] - 1'b1;
              pc <= ret_pc; state <= S_EXEC;
            end
            // Append: head read.
            6'd20: begin
              hd <= rdat[LW-1:0];
              if (rdat[LW-1:0] == EMPTY) begin
                e_we <= 1'b1; e_wa <= prevr | ea(3'd0, LW'(e)); e_wd <= DW'(e);
                h_we <= 1'b1; h_wa <= ha(hreg, hidx); h_wd <= DW'(e);
                pc <= 6'd24; state <= S_EXEC;
              end else begin
                rd_ent <= 1'b1; rd_ea <= prevr | ea(3'd0, rdat[LW-1:0]); pc <= 6'd21;
              end
            end
            6'd21: begin
              tl <= LW'(rdat[EW-1:0]);
              e_we <= 1'b1; e_wa <= prevr | ea(3'd0, LW'(e)); e_wd <= DW'(rdat[EW-1:0]);
              pc <= 6'd22; state <= S_EXEC;
            end
            6'd22: begin
              e_we <= 1'b1; e_wa <= nextr | ea(3'd0, tl); e_wd <= DW'(e);
              pc <= 6'd23; state <= S_EXEC;
            end
            6'd23: begin
              e_we <= 1'b1; e_wa <= prevr | ea(3'd0, hd); e_wd <= DW'(e);
              pc <= 6'd24; state <= S_EXEC;
            end
            6'd24: begin
              e_we <= 1'b1; e_wa <= nextr | ea(3'd0, LW'(e)); e_wd <= DW'(EMPTY);
              if (lsec) begin
                pc <= 6'd25; state <= S_EXEC;
              end else begin
                rd_ent <= 1'b0; rd_ha <= ha(H_CNT, hidx); pc <= 6'd26;
              end
            end
            6'd25: begin
              e_we <= 1'b1; e_wa <= ea(R_ESEC, LW'(e)); e_wd <= DW'({1'b0, tsec});
              pc <= ret_pc; state <= S_EXEC;
            end
            6'd26: begin
              h_we <= 1'b1; h_wa <= ha(H_CNT, hidx); h_wd <= DW'(rdat[CW-1:0] + 1'b1);
              e_we <= 1'b1; e_wa <= ea(R_ESTA, LW'(e)); e_wd <= DW'(hidx);
              cnt <= rdat[CW-1:0] + 1'b1;
              pc <= ret_pc; state <= S_EXEC;
            end
            // After status unlink for allocate / change status: append to tsta.
            6'd30: begin
              lsec <= 1'b0; lidx <= HW'(tsta);
              ret_pc <= (op == FUNC_ALLOC) ? 6'd32 : 6'd41;
              rd_ent <= 1'b0; rd_ha <= ha(H_THEAD, HW'(tsta)); pc <= 6'd20;
            end
            // Delete: status unlinked; save count, then sector unlink.
            6'd31: begin
              res_cnt <= 13'(cnt);
              lsec <= 1'b1; lidx <= HW'(old_sec[SEW-1:0]); ret_pc <= 6'd34;
              if (old_sec[SEW]) begin
                pc <= 6'd34; state <= S_EXEC;
              end else begin
                rd_ent <= 1'b0; rd_ha <= ha(H_SHEAD, HW'(old_sec[SEW-1:0])); pc <= 6'd10;
              end
            end
            // Allocate: status appended; now sector append.
            6'd32: begin
              res_cnt <= 13'(cnt);
              lsec <= 1'b1; lidx <= HW'(tsec); ret_pc <= 6'd42;
              rd_ent <= 1'b0; rd_ha <= ha(H_SHEAD, HW'(tsec)); pc <= 6'd20;
            end
            // Change sector: unlinked (or was in none); append to tsec.
            6'd33: begin
              lsec <= 1'b1; lidx <= HW'(tsec); ret_pc <= 6'd35;
              rd_ent <= 1'b0; rd_ha <= ha(H_SHEAD, HW'(tsec)); pc <= 6'd20;
            end
            // Delete: mark no sector, append to free bucket.
            6'd34: begin
              e_we <= 1'b1; e_wa <= ea(R_ESEC, LW'(e)); e_wd <= DW'({1'b1, {SEW{1'b0}}});
              lsec <= 1'b0; lidx <= HW'(FREE_B); ret_pc <= 6'd42;
              rd_ent <= 1'b0; rd_ha <= ha(H_THEAD, HW'(FREE_B)); pc <= 6'd20;
            end
            // Change sector: read own status count.
            6'd35: begin
              rd_ent <= 1'b0; rd_ha <= ha(H_CNT, HW'(old_sta)); pc <= 6'd40;
            end
            // Count read completes the result.
            6'd40: begin
              res_cnt <= 13'(rdat[CW-1:0]);
              res_v <= 1'b1; state <= S_DONE;
            end
            6'd41: begin
              res_cnt <= 13'(cnt);
              res_v <= 1'b1; state <= S_DONE;
            end
            6'd42: begin
              res_v <= 1'b1; state <= S_DONE;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Read addresses for the two memories.
  assign e_ra = rd_ea;
  assign h_ra = rd_ha;
endmodule

/* design/iblm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module iblm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
